// ===== sv/trfp_pkg.sv =====
// Shared types, codes and limits for the token request frame parser.
// No dependencies; every other file imports this package.
package trfp_pkg;

  // Design limits (fixed by the field widths of the ports).
  localparam int MAX_TOKEN_COUNT = 64;
  localparam int MAX_TOKEN_BYTES = 1048576;
  localparam int CONSUMED_WIDTH  = 24;
  localparam int CONS_PORT_W     = 24;

  localparam logic [7:0]  CH_LF   = 8'h0A;
  localparam logic [7:0]  CH_CR   = 8'h0D;
  localparam logic [20:0] NUM_SAT = 21'h1FFFFF;

  // Effective ceilings applied on top of the configuration registers.
  localparam int CNT_CEIL = (MAX_TOKEN_COUNT < 64) ? MAX_TOKEN_COUNT : 64;
  localparam int LEN_CEIL = (MAX_TOKEN_BYTES < 2097150) ? MAX_TOKEN_BYTES : 2097150;
  localparam logic [6:0]  CNT_LIMIT = 7'(CNT_CEIL);
  localparam logic [20:0] LEN_LIMIT = 21'(LEN_CEIL);

  // Register indexes.
  localparam logic REG_MAX_TOKENS = 1'b0;
  localparam logic REG_MAX_LEN    = 1'b1;

  // Event codes.
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_BYTE     = 3'd1;
  localparam logic [2:0] EV_EMPTY    = 3'd2;
  localparam logic [2:0] EV_COMPLETE = 3'd3;
  localparam logic [2:0] EV_ERROR    = 3'd4;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_COUNT = 3'd1;
  localparam logic [2:0] ERR_ZERO_CNT  = 3'd2;
  localparam logic [2:0] ERR_BAD_LEN   = 3'd3;
  localparam logic [2:0] ERR_NO_TERM   = 3'd4;
  localparam logic [2:0] ERR_LIMIT     = 3'd5;

  // Queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] upper;
    logic       is_lf;
    logic       is_cr;
    logic       is_digit;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic [6:0]  max_tokens;
    logic [20:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [2:0]             event_res;
    logic [7:0]             data_byte;
    logic [5:0]             token_number;
    logic                   last_of_token;
    logic [2:0]             error_kind;
    logic [CONS_PORT_W-1:0] bytes_used;
  } result_t;

endpackage

// ===== sv/trfp_front.sv =====
// Front stage: accepts raw bytes and classifies them (LF, CR, digit, uppercase).
// Depends on trfp_pkg.
module trfp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  output logic          f_valid,
  input  logic          f_ready,
  output trfp_pkg::item_t f_item
);
  import trfp_pkg::*;

  item_t cls;

  always_comb begin
    cls          = '0;
    cls.raw      = in_byte;
    cls.is_lf    = (in_byte == CH_LF);
    cls.is_cr    = (in_byte == CH_CR);
    cls.is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    cls.digit    = in_byte[3:0];
    // ASCII a..z -> A..Z
    if ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) begin
      cls.upper = in_byte - 8'h20;
    end else begin
      cls.upper = in_byte;
    end
  end

  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item <= cls;
    end
  end

endmodule

// ===== sv/trfp_queue.sv =====
// Short item queue between the classifier and the parser.
// Depends on trfp_pkg.
module trfp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_valid,
  output logic            s_ready,
  input  trfp_pkg::item_t s_item,
  output logic            m_valid,
  input  logic            m_pop,
  output trfp_pkg::item_t m_item
);
  import trfp_pkg::*;

  item_t          slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            push;

  assign s_ready = (count != (Q_AW+1)'(Q_DEPTH));
  assign m_valid = (count != '0);
  assign m_item  = slots[rd_ptr];
  assign push    = s_valid && s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (m_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !m_pop) begin
        count <= count + 1'b1;
      end else if (!push && m_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= s_item;
    end
  end

endmodule

// ===== sv/trfp_back.sv =====
// Back stage: request parser state machine and registered result.
// Depends on trfp_pkg.
module trfp_back #(
  parameter int CONSUMED_WIDTH = trfp_pkg::CONSUMED_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  trfp_pkg::item_t   q_item,
  input  trfp_pkg::cfg_t    cfg,
  output logic              res_valid,
  input  logic              res_ready,
  output trfp_pkg::result_t res
);
  import trfp_pkg::*;

  localparam int CW = (CONSUMED_WIDTH < CONS_PORT_W) ? CONSUMED_WIDTH : CONS_PORT_W;
  localparam logic [CW-1:0] CAP = '1;

  localparam logic [2:0] PH_COUNT   = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_TERM    = 3'd3;
  localparam logic [2:0] PH_TERM_LF = 3'd4;

  logic [2:0]    phase, phase_next;
  logic [20:0]   number_value, number_value_next;
  logic          line_has_digit, line_has_digit_next;
  logic          line_is_bad, line_is_bad_next;
  logic          pending_cr, pending_cr_next;
  logic [6:0]    token_total, token_total_next;
  logic [5:0]    token_index, token_index_next;
  logic [20:0]   bytes_left, bytes_left_next;
  logic [CW-1:0] byte_counter, byte_counter_next;

  result_t       res_next;
  logic [CW-1:0] ctr_inc;
  logic [CW-1:0] cons;
  logic [24:0]   num_mul;
  logic [20:0]   num_upd;
  logic [6:0]    cnt_lim;
  logic [20:0]   len_lim;
  logic [20:0]   bl_dec;
  logic [6:0]    idx_inc;
  logic          end_bad;
  logic          done_token;
  logic          clr;
  logic          seed_term;
  logic          seed_term_lf;
  logic [2:0]    err;
  logic [2:0]    ev;

  assign q_pop = q_valid && (!res_valid || res_ready);

  always_comb begin
    phase_next          = phase;
    number_value_next   = number_value;
    line_has_digit_next = line_has_digit;
    line_is_bad_next    = line_is_bad;
    pending_cr_next     = pending_cr;
    token_total_next    = token_total;
    token_index_next    = token_index;
    bytes_left_next     = bytes_left;
    res_next            = '0;
    ev                  = EV_NONE;
    err                 = ERR_NONE;
    cons                = '0;
    done_token          = 1'b0;
    clr                 = 1'b0;
    seed_term           = 1'b0;
    seed_term_lf        = 1'b0;

    ctr_inc           = (byte_counter == CAP) ? CAP : byte_counter + 1'b1;
    byte_counter_next = ctr_inc;

    // number_value * 10 + digit, saturating at 21 bits
    num_mul = ({4'b0, number_value} << 3) + ({4'b0, number_value} << 1)
              + {21'b0, q_item.digit};
    num_upd = (num_mul > {4'b0, NUM_SAT}) ? NUM_SAT : num_mul[20:0];

    cnt_lim = (cfg.max_tokens < CNT_LIMIT) ? cfg.max_tokens : CNT_LIMIT;
    len_lim = (cfg.max_len < LEN_LIMIT) ? cfg.max_len : LEN_LIMIT;
    end_bad = line_is_bad || !line_has_digit;
    bl_dec  = (bytes_left == '0) ? '0 : bytes_left - 1'b1;
    idx_inc = {1'b0, token_index} + 7'd1;

    unique case (phase)
      PH_COUNT, PH_LENGTH: begin
        if (q_item.is_lf) begin
          number_value_next   = '0;
          line_has_digit_next = 1'b0;
          line_is_bad_next    = 1'b0;
          pending_cr_next     = 1'b0;
          if (phase == PH_COUNT) begin
            if (end_bad) begin
              err = ERR_BAD_COUNT;
            end else if (number_value == '0) begin
              err = ERR_ZERO_CNT;
            end else if (number_value > {14'b0, cnt_lim}) begin
              err = ERR_LIMIT;
            end else begin
              token_total_next = number_value[6:0];
              token_index_next = '0;
              phase_next       = PH_LENGTH;
            end
          end else begin
            if (end_bad) begin
              err = ERR_BAD_LEN;
            end else if (number_value > len_lim) begin
              err = ERR_LIMIT;
            end else if (number_value == '0) begin
              ev         = EV_EMPTY;
              res_next.token_number = token_index;
              phase_next = PH_TERM;
            end else begin
              bytes_left_next = number_value;
              phase_next      = PH_DATA;
            end
          end
          if (err != ERR_NONE) begin
            cons = ctr_inc;
            clr  = 1'b1;
          end
        end else begin
          // a CR not followed by LF, or any non-digit, marks the line bad
          pending_cr_next  = q_item.is_cr;
          line_is_bad_next = line_is_bad || pending_cr
                             || (!q_item.is_cr && !q_item.is_digit);
          if (q_item.is_digit) begin
            number_value_next   = num_upd;
            line_has_digit_next = 1'b1;
          end
        end
      end
      PH_DATA: begin
        ev                     = EV_BYTE;
        res_next.data_byte     = (token_index == '0) ? q_item.upper : q_item.raw;
        res_next.token_number  = token_index;
        res_next.last_of_token = (bytes_left <= 21'd1);
        bytes_left_next        = bl_dec;
        if (bl_dec == '0) begin
          phase_next = PH_TERM;
        end
      end
      PH_TERM: begin
        if (q_item.is_lf) begin
          done_token = 1'b1;
        end else if (q_item.is_cr) begin
          phase_next = PH_TERM_LF;
        end else begin
          err       = ERR_NO_TERM;
          cons      = byte_counter;
          clr       = 1'b1;
          seed_term = 1'b1;
        end
      end
      PH_TERM_LF: begin
        if (q_item.is_lf) begin
          done_token = 1'b1;
        end else begin
          // the CR is given back to the next request's count line
          err          = ERR_NO_TERM;
          cons         = (byte_counter == CAP || byte_counter == '0) ?
                         byte_counter : byte_counter - 1'b1;
          clr          = 1'b1;
          seed_term_lf = 1'b1;
        end
      end
      default: begin
        clr = 1'b1;
      end
    endcase

    if (done_token) begin
      if (idx_inc >= token_total) begin
        ev   = EV_COMPLETE;
        cons = ctr_inc;
        clr  = 1'b1;
      end else begin
        token_index_next = idx_inc[5:0];
        phase_next       = PH_LENGTH;
      end
    end

    if (clr) begin
      phase_next          = PH_COUNT;
      number_value_next   = '0;
      line_has_digit_next = 1'b0;
      line_is_bad_next    = 1'b0;
      pending_cr_next     = 1'b0;
      token_total_next    = '0;
      token_index_next    = '0;
      bytes_left_next     = '0;
      byte_counter_next   = '0;
    end

    // offending byte opens the new count line
    if (seed_term || seed_term_lf) begin
      byte_counter_next = seed_term ? CW'(1) : CW'(2);
      pending_cr_next   = q_item.is_cr;
      line_is_bad_next  = seed_term_lf || !q_item.is_digit;
      if (q_item.is_digit) begin
        number_value_next   = {17'b0, q_item.digit};
        line_has_digit_next = 1'b1;
      end
    end

    if (err != ERR_NONE) begin
      ev = EV_ERROR;
    end

    res_next.event_res  = ev;
    res_next.error_kind = err;
    res_next.bytes_used = CONS_PORT_W'(cons);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_COUNT;
      number_value   <= '0;
      line_has_digit <= 1'b0;
      line_is_bad    <= 1'b0;
      pending_cr     <= 1'b0;
      token_total    <= '0;
      token_index    <= '0;
      bytes_left     <= '0;
      byte_counter   <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        phase          <= phase_next;
        number_value   <= number_value_next;
        line_has_digit <= line_has_digit_next;
        line_is_bad    <= line_is_bad_next;
        pending_cr     <= pending_cr_next;
        token_total    <= token_total_next;
        token_index    <= token_index_next;
        bytes_left     <= bytes_left_next;
        byte_counter   <= byte_counter_next;
        res_valid      <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= res_next;
    end
  end

endmodule

// ===== sv/token_request_frame_parser_top.sv =====
// Top level of the token request frame parser: config registers, front,
// queue and back stages. Depends on trfp_pkg, trfp_front, trfp_queue, trfp_back.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  in      | in  | in_valid / in_ready    | in_byte
//  out     | out | out_valid / out_ready  | event_res, data_byte, token_number,
//          |     |                        | last_of_token, error_kind,
//          |     |                        | bytes_used
//  cfg     | in  | cfg_en (no wait)       | cfg_index, cfg_data
//
// One result item per input item, one item per cycle sustained while the output is not stalled.
// From the input accept to result valid, an item is held in the front register, then
// written to a queue slot, and the parser step then loads the result register.
// The parser state update (digit accumulate, limit compare) is the single
// per-byte step; it runs once per cycle in the back stage while an item is popped.
// Synchronous reset returns the parser to the count line and loads
// max_tokens = 64, max_token_length = 1048576; no clearing pass.
// A stalled output holds the result register; the 2-entry queue and the
// front register keep taking items until both fill.

module token_request_frame_parser_top #(
  parameter int CONSUMED_WIDTH = trfp_pkg::CONSUMED_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [5:0]  token_number,
  output logic        last_of_token,
  output logic [2:0]  error_kind,
  output logic [23:0] bytes_used,
  input  logic        cfg_en,
  input  logic        cfg_index,
  input  logic [20:0] cfg_data
);
  import trfp_pkg::*;

  cfg_t    cfg;
  item_t   f_item;
  item_t   q_item;
  result_t res;
  logic    f_valid;
  logic    f_ready;
  logic    q_valid;
  logic    q_pop;

  // Configuration registers; the user must write them only while no item is in flight (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_tokens <= 7'd64;
      cfg.max_len    <= 21'h100000;
    end else if (cfg_en) begin
      if (cfg_index == REG_MAX_TOKENS) begin
        cfg.max_tokens <= cfg_data[6:0];
      end else if (cfg_index == REG_MAX_LEN) begin
        cfg.max_len <= cfg_data;
      end
    end
  end

  trfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_item   (f_item)
  );

  trfp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .s_valid (f_valid),
    .s_ready (f_ready),
    .s_item  (f_item),
    .m_valid (q_valid),
    .m_pop   (q_pop),
    .m_item  (q_item)
  );

  trfp_back #(
    .CONSUMED_WIDTH (CONSUMED_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .cfg       (cfg),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign event_res     = res.event_res;
  assign data_byte     = res.data_byte;
  assign token_number  = res.token_number;
  assign last_of_token = res.last_of_token;
  assign error_kind    = res.error_kind;
  assign bytes_used    = res.bytes_used;

  // Error code present exactly on error events.
  a_err_kind : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((error_kind != ERR_NONE) == (event_res == EV_ERROR)))
    else $error("error_kind and event_res disagree");

  // Byte count only reported on completion or error.
  a_cons : assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_COMPLETE && event_res != EV_ERROR)
      |-> (bytes_used == '0))
    else $error("bytes_used set on a non-terminal event");

  // Data and last flag only on token byte events.
  a_data : assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_BYTE) |-> (data_byte == '0 && !last_of_token))
    else $error("token byte fields set on a non-byte event");

  // A completed request always reports at least the count line bytes.
  a_cmpl : assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_COMPLETE) |-> (bytes_used >= 24'd4))
    else $error("request completion with too few bytes");

endmodule

// ===== tb/tb_token_request_frame_parser_top.sv =====
// Self-checking testbench for token_request_frame_parser_top: directed frames, then random
// request streams under several register settings, checked item by item against a local parser.
// Depends on trfp_pkg and the RTL of token_request_frame_parser_top.
module tb_token_request_frame_parser_top;
  import trfp_pkg::*;

  localparam int          NUM_PHASES      = 7;
  localparam int          ITEMS_PER_PHASE = 85;
  localparam int          HOLD_CYCLES     = 80;   // long receiver hold-off
  localparam int          DRAIN_CYCLES    = 8;    // margin for a stray trailing result
  localparam int unsigned LIMIT_CYCLES    = 200000;
  localparam logic [23:0] CONS_CAP = (CONSUMED_WIDTH >= 24) ? 24'hFFFFFF :
                                     24'((64'd1 << CONSUMED_WIDTH) - 64'd1);

  // Parser phases of the local prediction.
  typedef enum logic [2:0] {PS_COUNT, PS_LENGTH, PS_DATA, PS_TERM, PS_TERM_LF} parse_phase_t;

  // One row of the opening frames: byte, and a typed-in result where it is obvious.
  typedef struct packed {
    logic [7:0]  code;
    logic        typed;
    logic [2:0]  ev;
    logic [2:0]  err;
    logic [23:0] cons;
  } step_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [5:0]  token_number;
  logic        last_of_token;
  logic [2:0]  error_kind;
  logic [23:0] bytes_used;
  logic        cfg_en    = 1'b0;
  logic        cfg_index = REG_MAX_TOKENS;
  logic [20:0] cfg_data  = '0;

  token_request_frame_parser_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .data_byte     (data_byte),
    .token_number  (token_number),
    .last_of_token (last_of_token),
    .error_kind    (error_kind),
    .bytes_used    (bytes_used),
    .cfg_en        (cfg_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Local copy of the parser state and of the two limit registers.
  parse_phase_t pstate;
  logic [20:0]  num_val;
  logic         has_digit;
  logic         bad_line;
  logic         cr_held;
  logic [6:0]   tok_total;
  logic [5:0]   tok_idx;
  logic [20:0]  left;
  logic [23:0]  byte_cnt;
  logic [6:0]   lim_tokens = 7'd64;
  logic [20:0]  lim_len    = 21'd1048576;

  result_t     due_events [$];   // predicted results, oldest first
  logic [7:0]  tx_bytes [$];     // generated request stream not yet offered
  int          mismatches    = 0;
  int unsigned cycle_count   = 0;
  bit          hold_off_req  = 1'b0;

  // Opening frames, all under reset limits (64 tokens, 1 MiB).
  step_t opening_steps [25] = '{
    '{CH_LF,  1'b1, EV_ERROR,    ERR_BAD_COUNT, 24'd1},  // empty count line
    '{"0",    1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{CH_LF,  1'b1, EV_ERROR,    ERR_ZERO_CNT,  24'd2},  // zero count
    '{"1",    1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{CH_CR,  1'b1, EV_NONE,     ERR_NONE,      24'd0},  // lone CR waits
    '{CH_LF,  1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{"0",    1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{CH_CR,  1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{CH_LF,  1'b1, EV_EMPTY,    ERR_NONE,      24'd0},  // zero length token 0
    '{CH_CR,  1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{CH_LF,  1'b1, EV_COMPLETE, ERR_NONE,      24'd8},
    '{"2",    1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{CH_LF,  1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{"2",    1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{CH_LF,  1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{"a",    1'b0, EV_NONE,     ERR_NONE,      24'd0},  // uppercased
    '{8'hFF,  1'b0, EV_NONE,     ERR_NONE,      24'd0},  // top byte, last of token
    '{8'h00,  1'b1, EV_ERROR,    ERR_NO_TERM,   24'd6},  // missing terminator
    '{CH_LF,  1'b1, EV_ERROR,    ERR_BAD_COUNT, 24'd2},  // 0x00 opened a bad count line
    '{CH_CR,  1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{"7",    1'b1, EV_NONE,     ERR_NONE,      24'd0},  // CR not before LF spoils the line
    '{CH_LF,  1'b1, EV_ERROR,    ERR_BAD_COUNT, 24'd3},
    '{"6",    1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{"5",    1'b1, EV_NONE,     ERR_NONE,      24'd0},
    '{CH_LF,  1'b1, EV_ERROR,    ERR_LIMIT,     24'd3}   // count above 64
  };

  // Register settings per random phase; both extremes of each register appear.
  logic [6:0]  plan_tokens [NUM_PHASES] = '{7'd1, 7'd64, 7'd2, 7'd5, 7'd64, 7'd1, 7'd17};
  logic [20:0] plan_len    [NUM_PHASES] = '{21'd0, 21'd1048576, 21'd3, 21'd1, 21'd20,
                                            21'd1048576, 21'd6};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void restart_line();
    num_val   = '0;
    has_digit = 1'b0;
    bad_line  = 1'b0;
    cr_held   = 1'b0;
  endfunction

  function automatic void restart_request();
    pstate = PS_COUNT;
    restart_line();
    tok_total = '0;
    tok_idx   = '0;
    left      = '0;
    byte_cnt  = '0;
  endfunction

  // Adds one byte to the current count or length line; returns 1 when the line ends.
  function automatic bit feed_line(logic [7:0] c);
    int unsigned acc;
    if (cr_held) begin
      cr_held = 1'b0;
      if (c == CH_LF) return 1'b1;
      bad_line = 1'b1;   // CR that was not part of CR LF
    end
    if (c == CH_LF) return 1'b1;
    if (c == CH_CR) begin
      cr_held = 1'b1;
    end else if (c >= "0" && c <= "9") begin
      acc = 32'(num_val) * 32'd10 + 32'(c - "0");
      num_val = (acc > 32'(NUM_SAT)) ? NUM_SAT : 21'(acc);
      has_digit = 1'b1;
    end else begin
      bad_line = 1'b1;
    end
    return 1'b0;
  endfunction

  // One parser step: the result this byte must produce, with the state advanced.
  function automatic result_t parse_byte(logic [7:0] c);
    result_t     r;
    logic [23:0] prev;
    bit          tok_done;
    bit          bad;
    int unsigned v;
    int unsigned ceil;
    logic [6:0]  nxt;
    r        = '0;
    tok_done = 1'b0;
    prev     = byte_cnt;
    byte_cnt = (prev >= CONS_CAP) ? CONS_CAP : prev + 24'd1;
    case (pstate)
      PS_COUNT: begin
        if (feed_line(c)) begin
          v   = 32'(num_val);
          bad = bad_line || !has_digit;
          restart_line();
          ceil = 32'(lim_tokens);
          if (MAX_TOKEN_COUNT < ceil) ceil = MAX_TOKEN_COUNT;
          if (64 < ceil) ceil = 64;
          if (bad) r.error_kind = ERR_BAD_COUNT;
          else if (v == 0) r.error_kind = ERR_ZERO_CNT;   // zero wins over the limit
          else if (v > ceil) r.error_kind = ERR_LIMIT;
          else begin
            tok_total = 7'(v);
            tok_idx   = '0;
            pstate    = PS_LENGTH;
          end
          if (r.error_kind != ERR_NONE) begin
            r.bytes_used = byte_cnt;
            restart_request();
          end
        end
      end
      PS_LENGTH: begin
        if (feed_line(c)) begin
          v   = 32'(num_val);
          bad = bad_line || !has_digit;
          restart_line();
          ceil = 32'(lim_len);
          if (MAX_TOKEN_BYTES < ceil) ceil = MAX_TOKEN_BYTES;
          if (32'(NUM_SAT) - 1 < ceil) ceil = 32'(NUM_SAT) - 1;
          if (bad) r.error_kind = ERR_BAD_LEN;
          else if (v > ceil) r.error_kind = ERR_LIMIT;
          else if (v == 0) begin
            r.event_res    = EV_EMPTY;
            r.token_number = tok_idx;
            pstate         = PS_TERM;
          end else begin
            left   = 21'(v);
            pstate = PS_DATA;
          end
          if (r.error_kind != ERR_NONE) begin
            r.bytes_used = byte_cnt;
            restart_request();
          end
        end
      end
      PS_DATA: begin
        r.event_res     = EV_BYTE;
        r.data_byte     = (tok_idx == 0 && c >= "a" && c <= "z") ? c - 8'h20 : c;
        r.token_number  = tok_idx;
        r.last_of_token = (left <= 21'd1);
        left = (left == 0) ? '0 : left - 21'd1;
        if (left == 0) pstate = PS_TERM;
      end
      PS_TERM: begin
        if (c == CH_LF) tok_done = 1'b1;
        else if (c == CH_CR) pstate = PS_TERM_LF;
        else begin
          // offending byte is not consumed; it opens the next count line
          r.error_kind = ERR_NO_TERM;
          r.bytes_used = prev;
          restart_request();
          byte_cnt = 24'd1;
          void'(feed_line(c));
        end
      end
      PS_TERM_LF: begin
        if (c == CH_LF) tok_done = 1'b1;
        else begin
          // both the CR and the offending byte move to the next request
          r.error_kind = ERR_NO_TERM;
          r.bytes_used = (prev >= CONS_CAP || prev == 0) ? prev : prev - 24'd1;
          restart_request();
          byte_cnt = 24'd2;
          void'(feed_line(CH_CR));
          void'(feed_line(c));
        end
      end
      default: restart_request();
    endcase
    if (tok_done) begin
      nxt = {1'b0, tok_idx} + 7'd1;   // 7 bits: a 64th token must not wrap to zero
      if (nxt >= tok_total) begin
        r.event_res  = EV_COMPLETE;
        r.bytes_used = byte_cnt;
        restart_request();
      end else begin
        tok_idx = nxt[5:0];
        pstate  = PS_LENGTH;
      end
    end
    if (r.error_kind != ERR_NONE) r.event_res = EV_ERROR;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request stream generation
  // ---------------------------------------------------------------------------

  // LF or CR LF, evenly.
  task automatic push_term();
    if ($urandom_range(0, 1) != 0) tx_bytes.push_back(CH_CR);
    tx_bytes.push_back(CH_LF);
  endtask

  // Decimal line, sometimes with a leading zero.
  task automatic push_number(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) tx_bytes.push_back("0");
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
    push_term();
  endtask

  // A byte that is neither a digit nor a line character.
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_LF || b == CH_CR || (b >= "0" && b <= "9")) b = "x";
    return b;
  endfunction

  // Appends one request (mostly well formed) to tx_bytes. A broken request stops at the
  // fault, and a line end follows where the fault leaves the parser mid-line.
  task automatic queue_request(bit full);
    int unsigned pick, n, len, short_cap, long_cap, len_ceil;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    len_ceil = (lim_len < MAX_TOKEN_BYTES) ? lim_len : MAX_TOKEN_BYTES;
    if (!full && pick < 8) begin
      // line noise, biased toward the characters the parser cares about
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 4))
          0: b = 8'("0" + $urandom_range(0, 9));
          1: b = CH_CR;
          2: b = CH_LF;
          3: b = "z";
          default: b = 8'($urandom_range(0, 255));
        endcase
        tx_bytes.push_back(b);
      end
      tx_bytes.push_back(CH_LF);
    end else if (!full && pick < 12) begin
      // malformed count line
      case ($urandom_range(0, 2))
        0: ;                                  // empty line
        1: begin
          tx_bytes.push_back(CH_CR);
          tx_bytes.push_back("5");
        end
        default: begin
          tx_bytes.push_back("3");
          tx_bytes.push_back(junk_byte());
        end
      endcase
      push_term();
    end else if (!full && pick < 15) begin
      tx_bytes.push_back("0");
      push_term();
    end else if (!full && pick < 19) begin
      push_number((pick < 17) ? lim_tokens + 1 + $urandom_range(0, 2) : 99999999);
    end else begin
      if (full) n = 64;
      else if (pick < 30) n = (lim_tokens <= 8) ? lim_tokens : $urandom_range(5, 8);
      else n = $urandom_range(1, (lim_tokens < 4) ? lim_tokens : 4);
      push_number(n);
      for (int t = 0; t < n; t++) begin
        pick = $urandom_range(0, 99);
        if (!full && pick < 3) begin
          if ($urandom_range(0, 1) != 0) begin
            tx_bytes.push_back("2");
            tx_bytes.push_back(junk_byte());
          end
          push_term();
          return;
        end
        if (!full && pick < 6) begin
          push_number((pick < 5) ? len_ceil + 1 + $urandom_range(0, 3) : 99999999);
          return;
        end
        short_cap = (lim_len < (full ? 1 : 6)) ? lim_len : (full ? 1 : 6);
        long_cap  = (lim_len < 40) ? lim_len : 40;
        pick = $urandom_range(0, 99);
        if (full || pick < 75) len = $urandom_range(0, short_cap);
        else if (pick < 90) len = $urandom_range(0, long_cap);
        else len = long_cap;
        push_number(len);
        repeat (len) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: b = 8'("a" + $urandom_range(0, 25));
            4: b = ($urandom_range(0, 1) != 0) ? 8'h60 : 8'h7B;  // just outside a..z
            default: b = 8'($urandom_range(0, 255));
          endcase
          tx_bytes.push_back(b);
        end
        pick = $urandom_range(0, 99);
        if (!full && pick < 3) begin
          tx_bytes.push_back(junk_byte());
          tx_bytes.push_back(CH_LF);
          return;
        end
        if (!full && pick < 6) begin
          tx_bytes.push_back(CH_CR);
          tx_bytes.push_back(junk_byte());
          tx_bytes.push_back(CH_LF);
          return;
        end
        push_term();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one item, holds it until accepted, then records what it must produce.
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t typed_res);
    result_t predicted;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    predicted = parse_byte(b);
    due_events.push_back(typed ? typed_res : predicted);
  endtask

  // One register write; the caller drops cfg_en after the last one.
  task automatic write_reg(input logic idx, input logic [20:0] val);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_MAX_TOKENS) lim_tokens = val[6:0];
    else lim_len = val;
  endtask

  initial begin : stimulus
    result_t     fixed;
    int unsigned sent;
    int unsigned burst_left;
    int unsigned gap;
    restart_request();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Opening frames, back to back.
    foreach (opening_steps[i]) begin
      fixed = '0;
      fixed.event_res  = opening_steps[i].ev;
      fixed.error_kind = opening_steps[i].err;
      fixed.bytes_used = opening_steps[i].cons;
      send_byte(opening_steps[i].code, opening_steps[i].typed, fixed);
    end

    for (int pi = 0; pi < NUM_PHASES; pi++) begin
      // Registers change only with nothing in flight (every item gives one result).
      in_valid <= 1'b0;
      while (due_events.size() != 0) @(posedge clk);
      write_reg(REG_MAX_TOKENS, 21'(plan_tokens[pi]));
      write_reg(REG_MAX_LEN, plan_len[pi]);
      cfg_en <= 1'b0;
      if (pi == 3) hold_off_req = 1'b1;   // receiver stops; sender keeps pushing
      sent       = 0;
      burst_left = $urandom_range(1, 24);
      while (sent < ITEMS_PER_PHASE || tx_bytes.size() != 0) begin
        // one 64-token request when the token limit is at its top
        if (tx_bytes.size() == 0) queue_request(pi == 1 && sent == 0);
        if (pi == 2 && sent == ITEMS_PER_PHASE / 2) begin
          // sender waits out every pending result mid-stream
          in_valid <= 1'b0;
          while (due_events.size() != 0) @(posedge clk);
        end else if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          if (gap != 0 && !hold_off_req) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        send_byte(tx_bytes.pop_front(), 1'b0, '0);
        if (burst_left != 0) burst_left--;
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);   // catch any stray trailing result
    if (mismatches == 0 && due_events.size() == 0) begin
      $display("token_request_frame_parser_top test passed");
    end else begin
      $display("token_request_frame_parser_top test failed");
    end
    $finish;
  end

  // Receiver: stretches of always-ready, coin-flip, mostly-stalled and mostly-ready,
  // plus one long hold-off on request so the queue fills and in_ready drops.
  initial begin : ready_pattern
    int unsigned mode;
    int unsigned span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 40);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_off_req) begin
          out_ready <= 1'b0;
          for (int h = 1; h < HOLD_CYCLES; h++) @(posedge clk);
          hold_off_req = 1'b0;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) != 0);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [23:0] want_v, logic [23:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Sampled at the edge, before the block's own updates land.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_events.size() == 0) begin
        $display("%0t: unexpected result, event %0d expected none", $time, event_res);
        mismatches++;
      end else begin
        want = due_events.pop_front();
        check_field("event_res", 24'(want.event_res), 24'(event_res));
        check_field("data_byte", 24'(want.data_byte), 24'(data_byte));
        check_field("token_number", 24'(want.token_number), 24'(token_number));
        check_field("last_of_token", 24'(want.last_of_token), 24'(last_of_token));
        check_field("error_kind", 24'(want.error_kind), 24'(error_kind));
        check_field("bytes_used", want.bytes_used, bytes_used);
      end
    end
  end

  // Watchdog; the limit is many times the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("token_request_frame_parser_top test failed");
      $finish;
    end
  end

endmodule
